>>> rtl/overwriting_byte_ring_buffer_macros.svh
// Assertion macros shared by the ring buffer modules.
`ifndef OVERWRITING_BYTE_RING_BUFFER_MACROS_SVH
`define OVERWRITING_BYTE_RING_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBRB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obrb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OBRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obrb: next-cycle check failed");

`endif

>>> rtl/obrb_pkg.sv
// Shared types, constants and helpers for the overwriting byte ring buffer.
package obrb_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int LEN_W  = IDX_W + 1;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 6;

   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);
   localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(64);

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOOK,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic look;
      logic load;
   } cmd_type;

   typedef struct packed {
      byte_type oldest_byte;
      byte_type newest_byte;
      logic     byte_valid;
      fill_type fill_count;
      logic     is_empty;
      logic     dropped_oldest;
   } rsp_payload_type;

   // Step an index forward, wrapping at the ring length.
   function automatic idx_type ring_advance(idx_type i, len_type len);
      len_type n;
      n = len_type'(i) + len_type'(1);
      return (n >= len) ? '0 : n[IDX_W-1:0];
   endfunction

endpackage

>>> rtl/obrb_req_if.sv
// Request channel: operation kind and byte, with valid/ready handshake.
interface obrb_req_if import obrb_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

>>> rtl/obrb_rsp_if.sv
// Response channel: ring status fields, with valid/ready handshake.
interface obrb_rsp_if import obrb_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type oldest_byte;
   byte_type newest_byte;
   logic     byte_valid;
   fill_type fill_count;
   logic     is_empty;
   logic     dropped_oldest;

   modport source (output valid, output oldest_byte, output newest_byte,
                   output byte_valid, output fill_count, output is_empty,
                   output dropped_oldest, input ready);
   modport sink   (input valid, input oldest_byte, input newest_byte,
                   input byte_valid, input fill_count, input is_empty,
                   input dropped_oldest, output ready);
endinterface

>>> rtl/overwriting_byte_ring_buffer.sv
// Overwriting byte ring buffer: a byte FIFO of csr capacity entries that drops
// the oldest byte when a push fills it, so it holds at most capacity minus one
// bytes. Each request (push, pop, clear, status) gives exactly one response
// with the front byte (the popped byte for a pop), the back byte, a valid
// mark, the fill count, empty, and whether this push dropped a byte. From
// acceptance to response an item passes through capture, index update and
// store write, the registered read of the front and back entries, and the
// load of the response register. The response register holds a finished
// result while the next request is accepted; the load of that next item then
// waits until the held response is taken, so a response stall delays the
// item. A capacity write resets both indices (the ring reads as empty) and
// keeps the stored bytes; capacity 0 acts as 1 and values above 64 act as
// 64. Write capacity only while idle.
module overwriting_byte_ring_buffer import obrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   obrb_req_if.sink          req_chan,
   obrb_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data
);

   cmd_type         cmd;
   rsp_payload_type payload;

   obrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   obrb_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_chan.kind),
      .req_data_byte (req_chan.data_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_payload   (payload)
   );

   assign rsp_chan.oldest_byte    = payload.oldest_byte;
   assign rsp_chan.newest_byte    = payload.newest_byte;
   assign rsp_chan.byte_valid     = payload.byte_valid;
   assign rsp_chan.fill_count     = payload.fill_count;
   assign rsp_chan.is_empty       = payload.is_empty;
   assign rsp_chan.dropped_oldest = payload.dropped_oldest;

endmodule

>>> rtl/obrb_ctrl.sv
// Sequencer for the ring buffer: item handshake, step commands, result valid.
`include "overwriting_byte_ring_buffer_macros.svh"

module obrb_ctrl import obrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_LOOK: cmd.look = 1'b1;
         ST_LOAD: cmd.load = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   // Hold the result until taken; a load refills it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `OBRB_ASSERT_NEXT(a_accept_runs, clock, reset, accept, state_ff == ST_EXEC)
   `OBRB_ASSERT_NEXT(a_exec_to_look, clock, reset, state_ff == ST_EXEC, state_ff == ST_LOOK)
   `OBRB_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load, !rsp_valid_ff || rsp_ready)
   `OBRB_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_valid_ff)

endmodule

>>> rtl/obrb_dp.sv
// Ring datapath: capacity, indices, byte store and result register.
`include "overwriting_byte_ring_buffer_macros.svh"

module obrb_dp import obrb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  kind_type        req_kind,
   input  byte_type        req_data_byte,
   input  logic            csr_wr_en,
   input  len_type         csr_wr_data,
   output rsp_payload_type rsp_payload
);

   byte_type store [DEPTH];

   len_type  cap_ff;
   idx_type  wr_idx_ff, wr_idx_in;
   idx_type  rd_idx_ff, rd_idx_in;
   kind_type kind_ff;
   byte_type data_ff;
   logic     dropped_ff, dropped_in;
   logic     pop_done_ff, pop_done_in;
   byte_type popped_ff;
   byte_type front_ff;
   byte_type back_ff;
   rsp_payload_type payload_ff, payload_in;

   len_type  ring_len;
   idx_type  wr_step;
   idx_type  rd_step;
   idx_type  back_idx;
   logic     empty;
   len_type  held;
   logic     store_we;

   always_comb begin
      if (cap_ff == '0) begin
         ring_len = len_type'(1);
      end else if (cap_ff > DEPTH_LEN) begin
         ring_len = DEPTH_LEN;
      end else begin
         ring_len = cap_ff;
      end
   end

   assign wr_step  = ring_advance(wr_idx_ff, ring_len);
   assign rd_step  = ring_advance(rd_idx_ff, ring_len);
   assign back_idx = (wr_idx_ff == '0) ? IDX_W'(ring_len - len_type'(1))
                                       : wr_idx_ff - idx_type'(1);
   assign empty    = (rd_idx_ff == wr_idx_ff);
   assign held     = (wr_idx_ff >= rd_idx_ff)
                   ? len_type'(wr_idx_ff) - len_type'(rd_idx_ff)
                   : len_type'(wr_idx_ff) + ring_len - len_type'(rd_idx_ff);
   assign store_we = cmd.exec && (kind_ff == KIND_PUSH);

   // Index update for the captured operation
   always_comb begin
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      dropped_in  = dropped_ff;
      pop_done_in = pop_done_ff;
      if (cmd.exec) begin
         dropped_in  = 1'b0;
         pop_done_in = 1'b0;
         case (kind_ff)
            KIND_PUSH: begin
               wr_idx_in = wr_step;
               if (wr_step == rd_idx_ff) begin
                  rd_idx_in  = rd_step;
                  dropped_in = 1'b1;
               end
            end
            KIND_POP: begin
               if (!empty) begin
                  rd_idx_in   = rd_step;
                  pop_done_in = 1'b1;
               end
            end
            KIND_CLEAR: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
            end
            default: begin
               wr_idx_in = wr_idx_ff;
            end
         endcase
      end
   end

   // Result fields from the updated indices and the two store reads
   always_comb begin
      payload_in                = payload_ff;
      if (cmd.load) begin
         payload_in.newest_byte    = empty ? '0 : back_ff;
         payload_in.fill_count     = held[FILL_W-1:0];
         payload_in.is_empty       = empty;
         payload_in.dropped_oldest = dropped_ff;
         if (kind_ff == KIND_POP) begin
            payload_in.oldest_byte = pop_done_ff ? popped_ff : '0;
            payload_in.byte_valid  = pop_done_ff;
         end else begin
            payload_in.oldest_byte = empty ? '0 : front_ff;
            payload_in.byte_valid  = !empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else if (csr_wr_en) begin
         cap_ff    <= csr_wr_data;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dropped_ff  <= 1'b0;
         pop_done_ff <= 1'b0;
      end else begin
         dropped_ff  <= dropped_in;
         pop_done_ff <= pop_done_in;
      end
   end

   // Captured item and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         data_ff <= req_data_byte;
      end
      if (cmd.look) begin
         popped_ff <= front_ff;
      end
      payload_ff <= payload_in;
   end

   // Byte store: one write port, two registered read ports (front and back)
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[wr_idx_ff] <= data_ff;
      end
      front_ff <= store[rd_idx_ff];
      back_ff  <= store[back_idx];
   end

   assign rsp_payload = payload_ff;

   `OBRB_ASSERT_SAME(a_wr_in_ring, clock, reset, 1'b1, len_type'(wr_idx_ff) < ring_len)
   `OBRB_ASSERT_SAME(a_rd_in_ring, clock, reset, 1'b1, len_type'(rd_idx_ff) < ring_len)
   `OBRB_ASSERT_NEXT(a_csr_clears, clock, reset, csr_wr_en, wr_idx_ff == '0 && rd_idx_ff == '0)

endmodule

>>> dv/obrb_ring_check.sv
// Ring buffer checker: tracks the ring, predicts each response and compares it.
module obrb_ring_check import obrb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   obrb_req_if              req_mon,
   obrb_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   byte_type        ring_copy [DEPTH];
   idx_type         wr_slot;
   idx_type         rd_slot;
   len_type         cap_reg;
   rsp_payload_type expected_rsps [$];
   int              mismatches = 0;

   assign fail_count = mismatches;

   function automatic len_type ring_len();
      if (cap_reg == '0) return len_type'(1);
      if (cap_reg > DEPTH_LEN) return DEPTH_LEN;
      return cap_reg;
   endfunction

   function automatic idx_type next_slot(idx_type i);
      len_type n;
      n = len_type'(i) + len_type'(1);
      return (n >= ring_len()) ? '0 : n[IDX_W-1:0];
   endfunction

   // Apply one operation to the tracked ring and return the response it gives.
   function automatic rsp_payload_type predict_ring_op(kind_type op, byte_type d);
      rsp_payload_type r;
      byte_type        popped;
      logic            pop_done;
      idx_type         back;
      len_type         len;
      len_type         fill;
      len      = ring_len();
      r        = '0;
      popped   = '0;
      pop_done = 1'b0;
      case (op)
         KIND_PUSH: begin
            ring_copy[wr_slot] = d;
            wr_slot = next_slot(wr_slot);
            // drop the oldest byte when the write index catches up
            if (wr_slot == rd_slot) begin
               rd_slot = next_slot(rd_slot);
               r.dropped_oldest = 1'b1;
            end
         end
         KIND_POP: begin
            if (rd_slot != wr_slot) begin
               popped   = ring_copy[rd_slot];
               rd_slot  = next_slot(rd_slot);
               pop_done = 1'b1;
            end
         end
         KIND_CLEAR: begin
            wr_slot = '0;
            rd_slot = '0;
         end
         default: ;
      endcase
      r.is_empty = (rd_slot == wr_slot);
      if (!r.is_empty) begin
         back = (wr_slot == '0) ? idx_type'(len - len_type'(1)) : wr_slot - idx_type'(1);
         r.oldest_byte = ring_copy[rd_slot];
         r.newest_byte = ring_copy[back];
      end
      if (op == KIND_POP) begin
         r.oldest_byte = popped;
         r.byte_valid  = pop_done;
      end else begin
         r.byte_valid = !r.is_empty;
      end
      if (wr_slot >= rd_slot) fill = len_type'(wr_slot) - len_type'(rd_slot);
      else fill = len_type'(wr_slot) + len - len_type'(rd_slot);
      r.fill_count = fill[FILL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         wr_slot = '0;
         rd_slot = '0;
         cap_reg = CAP_RESET;
         expected_rsps.delete();
      end else begin
         if (csr_wr_en) begin
            cap_reg = csr_wr_data;
            wr_slot = '0;
            rd_slot = '0;
         end
         // match the response before queuing a new item, so a stray one is caught
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with no item outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_mon.oldest_byte !== want.oldest_byte)
                  report_mismatch($sformatf("oldest_byte exp %0h got %0h",
                                            want.oldest_byte, rsp_mon.oldest_byte));
               if (rsp_mon.newest_byte !== want.newest_byte)
                  report_mismatch($sformatf("newest_byte exp %0h got %0h",
                                            want.newest_byte, rsp_mon.newest_byte));
               if (rsp_mon.byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid exp %0b got %0b",
                                            want.byte_valid, rsp_mon.byte_valid));
               if (rsp_mon.fill_count !== want.fill_count)
                  report_mismatch($sformatf("fill_count exp %0d got %0d",
                                            want.fill_count, rsp_mon.fill_count));
               if (rsp_mon.is_empty !== want.is_empty)
                  report_mismatch($sformatf("is_empty exp %0b got %0b",
                                            want.is_empty, rsp_mon.is_empty));
               if (rsp_mon.dropped_oldest !== want.dropped_oldest)
                  report_mismatch($sformatf("dropped_oldest exp %0b got %0b",
                                            want.dropped_oldest, rsp_mon.dropped_oldest));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(predict_ring_op(req_mon.kind, req_mon.data_byte));
      end
      pending_count <= expected_rsps.size();
   end

endmodule

>>> dv/overwriting_byte_ring_buffer_tb.sv
// Testbench top for the overwriting byte ring buffer: stimulus and verdict.
module overwriting_byte_ring_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import obrb_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_wr_en;
   len_type csr_wr_data;
   int      fail_count;
   int      pending_count;
   bit      idle_on;
   int      rsp_stall = 0;

   obrb_req_if req_chan();
   obrb_rsp_if rsp_chan();

   always #2 clock = ~clock;

   overwriting_byte_ring_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   obrb_ring_check ring_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Receiver: stall in random bursts while idling is on.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall > 0) begin
            rsp_stall      <= rsp_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall      <= $urandom_range(0, 13);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_op(kind_type op, byte_type d);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= op;
      req_chan.data_byte <= d;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drain all responses, let the block settle, then write the capacity.
   task automatic write_capacity(len_type cap);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(len_type cap, int n_items, int push_pct, int clear_pct,
                               bit idling);
      int       roll;
      kind_type op;
      write_capacity(cap);
      idle_on <= idling;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct) op = KIND_PUSH;
         else if (roll < push_pct + clear_pct) op = KIND_CLEAR;
         else if (roll < push_pct + clear_pct + 4) op = KIND_STATUS;
         else op = KIND_POP;
         send_op(op, byte_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.kind      <= KIND_STATUS;
      req_chan.data_byte <= '0;
      idle_on            <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty ring, fill, drain, over-pop, clear
      send_op(KIND_POP,    8'h5A);
      send_op(KIND_STATUS, 8'hFF);
      send_op(KIND_PUSH,   8'h00);
      send_op(KIND_PUSH,   8'hFF);
      send_op(KIND_STATUS, 8'h00);
      send_op(KIND_POP,    8'hA5);
      send_op(KIND_POP,    8'h00);
      send_op(KIND_POP,    8'h00);
      send_op(KIND_PUSH,   8'h81);
      send_op(KIND_PUSH,   8'h7E);
      send_op(KIND_CLEAR,  8'hFF);
      send_op(KIND_STATUS, 8'h00);
      // capacity write on a non-empty ring, then a ring that holds nothing
      send_op(KIND_PUSH,   8'h3C);
      write_capacity(len_type'(1));
      send_op(KIND_STATUS, 8'h00);
      send_op(KIND_PUSH,   8'hC3);
      send_op(KIND_POP,    8'h00);
      // zero capacity acts as one
      write_capacity(len_type'(0));
      send_op(KIND_PUSH,   8'h55);
      send_op(KIND_STATUS, 8'hAA);
      // small ring: overwrite the oldest byte
      write_capacity(len_type'(3));
      send_op(KIND_PUSH,   8'h11);
      send_op(KIND_PUSH,   8'h22);
      send_op(KIND_PUSH,   8'h33);
      send_op(KIND_POP,    8'h00);
      send_op(KIND_STATUS, 8'h00);

      random_phase(len_type'(64),  110, 85, 0, 1'b1);
      random_phase(len_type'(127),  40, 60, 1, 1'b1);
      random_phase(len_type'(1),    20, 50, 5, 1'b1);
      random_phase(len_type'(2),    20, 50, 5, 1'b0);
      random_phase(len_type'(0),    15, 50, 5, 1'b1);
      random_phase(len_type'(5),    30, 55, 5, 1'b1);
      random_phase(len_type'(17),   40, 60, 3, 1'b0);
      random_phase(len_type'(33),   50, 70, 2, 1'b1);
      random_phase(len_type'(63),   30, 45, 5, 1'b1);
      random_phase(len_type'(8),    40, 55, 3, 1'b0);

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> overwriting_byte_ring_buffer.f
+incdir+rtl
rtl/obrb_pkg.sv
rtl/obrb_req_if.sv
rtl/obrb_rsp_if.sv
rtl/obrb_ctrl.sv
rtl/obrb_dp.sv
rtl/overwriting_byte_ring_buffer.sv
dv/obrb_ring_check.sv
dv/overwriting_byte_ring_buffer_tb.sv
